@@ rtl/fpc_pkg.sv @@
// Shared types and constants for the Fermat prime checker.
package fpc_pkg;

    localparam int NUM_WORDS   = 5;
    localparam int WORD_W      = 31;
    localparam int NUM_W       = 63;
    localparam int CAND_W      = 64;
    localparam int ROUNDS_W    = 3;
    localparam int COUNT_W     = 32;
    localparam int BIT_IDX_W   = 6;
    localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD_START,
        ST_MOD_WAIT,
        ST_EXP_CHECK,
        ST_MUL_START,
        ST_MUL_WAIT,
        ST_SQR_START,
        ST_SQR_WAIT,
        ST_ROUND_END,
        ST_FINISH,
        ST_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture a new request
        logic mod_start;  // word mod (n-4) begins
        logic base_set;   // base set from the remainder, accumulator set to 1
        logic mul_start;  // acc = acc * x mod n begins
        logic sqr_start;  // x = x * x mod n begins
        logic exp_shift;  // exponent moves one bit right
        logic fail;       // round did not give 1
        logic next_round; // step to the next random word
        logic finish;     // update counter and best prime
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic trivial;    // verdict known without rounds
        logic no_round;   // no round left to run
        logic unit_done;  // multiply or mod unit finished
        logic exp_zero;
        logic exp_lsb;
        logic acc_one;
        logic last_round;
        logic failed;
    } t_status;

endpackage

@@ rtl/fpc_datapath.sv @@
// Datapath: bit-serial modular multiply and reduce unit, operands and records.
module fpc_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fpc_pkg::t_cmd                  i_cmd,
    input  logic [fpc_pkg::ROUNDS_W-1:0]   i_rounds,
    input  logic [fpc_pkg::CAND_W-1:0]     i_cand,
    input  logic [fpc_pkg::NUM_WORDS*fpc_pkg::WORD_W-1:0] i_words,
    output fpc_pkg::t_status               o_status,
    output logic [fpc_pkg::COUNT_W-1:0]    o_count,
    output logic                           o_prime,
    output logic [fpc_pkg::NUM_W-1:0]      o_best
);
    import fpc_pkg::*;

    logic [CAND_W-1:0]              r_cand;
    logic [NUM_WORDS*WORD_W-1:0]    r_words;
    logic [NUM_W-1:0]               r_n, r_x, r_acc, r_e, r_a, r_b, r_r;
    logic [BIT_IDX_W-1:0]           r_bit;
    logic                           r_busy, r_done;
    logic [2:0]                     r_round, r_limit;
    logic                           r_failed;
    logic [COUNT_W-1:0]             r_count;
    logic [NUM_W-1:0]               r_best;
    logic                           r_prime;
    logic                           r_to_acc;

    logic [NUM_W:0]   sh, sh_red, ad, ad_red;
    logic [NUM_W-1:0] step_r;
    logic             trivial_prime;
    logic [WORD_W-1:0] cur_word;

    assign cur_word = r_words[WORD_W-1:0];

    // One step of shift-and-add: r = 2r mod n, then add a if the b bit is set.
    always_comb begin
        sh     = {r_r, 1'b0};
        sh_red = (sh >= {1'b0, r_n}) ? sh - {1'b0, r_n} : sh;
        ad     = sh_red + {1'b0, r_a};
        ad_red = (ad >= {1'b0, r_n}) ? ad - {1'b0, r_n} : ad;
        step_r = r_b[r_bit] ? ad_red[NUM_W-1:0] : sh_red[NUM_W-1:0];
    end

    assign trivial_prime = (r_cand == 64'd2) || (r_cand == 64'd3);

    always_comb begin
        o_status.trivial    = r_cand[CAND_W-1] || (r_cand <= 64'd4);
        o_status.no_round   = (r_round >= r_limit);
        o_status.unit_done  = r_done;
        o_status.exp_zero   = (r_e == '0);
        o_status.exp_lsb    = r_e[0];
        o_status.acc_one    = (r_acc == 63'd1);
        o_status.last_round = ({1'b0, r_round} + 4'd1 >= {1'b0, r_limit});
        o_status.failed     = r_failed;
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (i_cmd.load) begin
            r_cand  <= i_cand;
            r_words <= i_words;
            r_n     <= i_cand[NUM_W-1:0];
            r_round <= '0;
            r_limit <= (i_rounds > 3'd5) ? 3'd5 : i_rounds;
            r_failed <= 1'b0;
        end
        if (i_cmd.mod_start) begin
            // word * 1 mod (n-4): the shift-and-add unit reduces the word.
            r_n   <= r_cand[NUM_W-1:0] - 63'd4;
            r_a   <= 63'd1;
            r_b   <= {{(NUM_W-WORD_W){1'b0}}, cur_word};
            r_r   <= '0;
            r_bit <= BIT_IDX_W'(NUM_W - 1);
        end
        // The product lands in acc or x by which was started.
        if (r_done) begin
            if (r_to_acc) r_acc <= r_r;
            else          r_x   <= r_r;
        end
        if (i_cmd.base_set) begin
            r_n   <= r_cand[NUM_W-1:0];
            r_x   <= r_r + 63'd2;
            r_acc <= 63'd1;
            r_e   <= r_cand[NUM_W-1:0] - 63'd1;
        end
        if (i_cmd.mul_start) begin
            r_a <= r_acc; r_b <= r_x; r_r <= '0;
            r_bit <= BIT_IDX_W'(NUM_W - 1);
            r_to_acc <= 1'b1;
        end
        if (i_cmd.sqr_start) begin
            r_a <= r_x; r_b <= r_x; r_r <= '0;
            r_bit <= BIT_IDX_W'(NUM_W - 1);
            r_to_acc <= 1'b0;
        end
        if (r_busy) begin
            r_r <= step_r;
            if (r_bit != '0) begin
                r_bit <= r_bit - 1'b1;
            end else begin
                r_done <= 1'b1;
            end
        end
        if (i_cmd.exp_shift) r_e <= r_e >> 1;
        if (i_cmd.fail) r_failed <= 1'b1;
        if (i_cmd.next_round) begin
            r_round <= r_round + 3'd1;
            r_words <= r_words >> WORD_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.mod_start || i_cmd.mul_start || i_cmd.sqr_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_bit == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_best  <= '0;
            r_prime <= 1'b0;
        end else if (i_cmd.finish) begin
            logic p;
            p = o_status.trivial ? trivial_prime : !r_failed;
            r_count <= r_count + 1'b1;
            r_prime <= p;
            if (p && r_cand[NUM_W-1:0] > r_best) r_best <= r_cand[NUM_W-1:0];
        end
    end

    assign o_count = r_count;
    assign o_prime = r_prime;
    assign o_best  = r_best;
endmodule

@@ rtl/fpc_ctrl.sv @@
// Controller state machine sequencing rounds and square-and-multiply steps.
module fpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_req,
    output logic              o_in_ready,
    input  fpc_pkg::t_status  i_status,
    output fpc_pkg::t_cmd     o_cmd,
    output logic              o_out_valid,
    input  logic              i_out_ready
);
    import fpc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_in_req) n_state = ST_MOD_START;
            ST_MOD_START: begin
                if (i_status.trivial || i_status.failed || i_status.no_round)
                    n_state = ST_FINISH;
                else n_state = ST_MOD_WAIT;
            end
            ST_MOD_WAIT:  if (i_status.unit_done) n_state = ST_EXP_CHECK;
            ST_EXP_CHECK: begin
                if (i_status.exp_zero)     n_state = ST_ROUND_END;
                else if (i_status.exp_lsb) n_state = ST_MUL_START;
                else                       n_state = ST_SQR_START;
            end
            ST_MUL_START: n_state = ST_MUL_WAIT;
            ST_MUL_WAIT:  if (i_status.unit_done) n_state = ST_SQR_START;
            ST_SQR_START: n_state = ST_SQR_WAIT;
            ST_SQR_WAIT:  if (i_status.unit_done) n_state = ST_EXP_CHECK;
            ST_ROUND_END: begin
                if (!i_status.acc_one || i_status.last_round) n_state = ST_FINISH;
                else n_state = ST_MOD_START;
            end
            ST_FINISH:    n_state = ST_OUT;
            ST_OUT:       if (i_out_ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE:      begin o_in_ready = 1'b1; o_cmd.load = i_in_req; end
            ST_MOD_START: begin
                // Zero rounds skip straight to a prime verdict.
                o_cmd.mod_start = !(i_status.trivial || i_status.failed ||
                                    i_status.no_round);
            end
            ST_MOD_WAIT:  o_cmd.base_set = i_status.unit_done;
            ST_MUL_START: o_cmd.mul_start = 1'b1;
            ST_SQR_START: begin o_cmd.sqr_start = 1'b1; o_cmd.exp_shift = 1'b1; end
            ST_ROUND_END: begin
                o_cmd.fail = !i_status.acc_one;
                o_cmd.next_round = 1'b1;
            end
            ST_FINISH:    o_cmd.finish = 1'b1;
            ST_OUT:       o_out_valid = 1'b1;
            default:      ;
        endcase
    end
endmodule

@@ rtl/fermat_prime_check_with_max_core.sv @@
// Top level of the Fermat prime checker with highest-prime record.
// Channel | Direction | Contents
// s_axis  | in        | tdata: candidate[63:0], random_word_0..4 (31 each) from bit 64 up
// m_axis  | out       | tdata: request_number[31:0], is_prime[32], top_prime[95:33]
// cfg     | in        | rounds, 3 bits
// One request at a time. A round first reduces its word in a pass of the
// shift-and-add unit, then walks up to 63 exponent bits: a square for each bit,
// and a multiply before it when the bit is set. A negative candidate or one
// below five is answered without running any round. The result holds until
// taken; no new request is accepted before then. Reset is synchronous and sets
// rounds to 5.
module fermat_prime_check_with_max_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [223:0] s_axis_tdata,  // candidate, random_word_0..4, pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,  // request_number, is_prime, top_prime
    input  logic         i_cfg_we,
    input  logic [fpc_pkg::ROUNDS_W-1:0] i_cfg_wdata
);
    import fpc_pkg::*;

    logic [ROUNDS_W-1:0] r_rounds;
    t_cmd    cmd;
    t_status status;
    logic [COUNT_W-1:0] count;
    logic prime;
    logic [NUM_W-1:0] best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_rounds <= ROUNDS_RESET;
        else if (i_cfg_we) r_rounds <= i_cfg_wdata;
    end

    fpc_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_req(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_status(status), .o_cmd(cmd),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready)
    );

    fpc_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_rounds(r_rounds),
        .i_cand(s_axis_tdata[63:0]),
        .i_words(s_axis_tdata[64 +: NUM_WORDS*WORD_W]),
        .o_status(status), .o_count(count), .o_prime(prime), .o_best(best)
    );

    assign m_axis_tdata = {best, prime, count};
endmodule

@@ rtl/fpc_checker.sv @@
// Port-level checker for the prime checker top level, with its bind.
module fpc_port_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while result pending");
    a_accept_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result with no work");
endmodule

bind fermat_prime_check_with_max_core fpc_port_props u_chk (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
